[design/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies. Each assumes clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TEQ_ASSERT_IMP(lbl, ante, cons)
`define TEQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/tevq_pkg.sv]
// Types and constants of the timed event queue.
// No dependencies.
`default_nettype none
package tevq_pkg;
  localparam int TIME_W  = 64;
  localparam int DEV_W   = 6;
  localparam int RSN_W   = 8;
  localparam int LIMIT_W = 6;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  typedef enum logic [1:0] {
    FUNC_INSERT, FUNC_DISPATCH, FUNC_FLUSH, FUNC_DISCARD
  } func_t;

  typedef enum logic [1:0] {
    ST_DISPATCHED, ST_NONE_DUE, ST_ACCEPTED, ST_FULL
  } status_t;

  // source of has_pending / earliest_time in a result
  typedef enum logic [1:0] {
    ERL_NONE, ERL_HEAD, ERL_AFTER_POP, ERL_AFTER_INS
  } erl_t;

  typedef enum logic {
    S_IDLE, S_EMIT
  } state_t;

  typedef struct packed {
    logic    ins;
    logic    pop;
    logic    clr;
    logic    latch;
    logic    load;
    status_t ostat;
    erl_t    erl;
    logic    runaway;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic head_valid;
    logic next_valid;
    logic full;
    logic head_due;
    logic next_due;
    logic head_same;
  } sts_t;
endpackage
`default_nettype wire

[design/timed_event_queue_core.sv]
// Timed event queue, top level: controller plus datapath.
// Depends on tevq_pkg, tevq_ctrl, tevq_dpath, assert_macros.svh.
//
// Time-ordered event queue of QUEUE_DEPTH entries held in a sorted
// shift-register array; equal times keep arrival order. An insert or a
// discard is one transfer in and one result out, and completes in the cycle
// it is accepted (the compare-and-shift across all cells is done in
// parallel). Dispatch (func 1) and flush (func 2) give one result per cycle
// while the output register drains: the controller pops the head in each
// cycle that the output register can load, up to 32 results per item.
// A new item is taken only once the previous one has issued its last
// result into the output register, and only while that register is empty
// or its result is being taken. The runaway limit is written with
// cfg_we/cfg_wdata while the block is idle; the count restarts per call,
// and for flush at each new time. No clearing pass: reset empties the queue.
`default_nettype none
`include "assert_macros.svh"
module timed_event_queue_core #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [63:0] in_time_value,
  input  wire logic [5:0]  in_device_id,
  input  wire logic [7:0]  in_reason_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [63:0]      out_fired_time,
  output logic [5:0]       out_fired_device,
  output logic [7:0]       out_fired_reason,
  output logic             out_runaway,
  output logic             out_has_pending,
  output logic [63:0]      out_earliest_time,
  output logic             out_last_result,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata
);
  import tevq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic multi_take;

  // sequencing, handshakes and the limit register
  tevq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  // queue cells and result register
  tevq_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_time_value     (in_time_value),
    .in_device_id      (in_device_id),
    .in_reason_code    (in_reason_code),
    .out_status        (out_status),
    .out_fired_time    (out_fired_time),
    .out_fired_device  (out_fired_device),
    .out_fired_reason  (out_fired_reason),
    .out_runaway       (out_runaway),
    .out_has_pending   (out_has_pending),
    .out_earliest_time (out_earliest_time),
    .out_last_result   (out_last_result),
    .rst_n             (rst_n)
  );

  // dispatch or flush transfer in this cycle
  assign multi_take = in_valid && in_ready &&
                      (in_func == FUNC_DISPATCH || in_func == FUNC_FLUSH);

  // a dispatch or flush transfer blocks input until its last result
  `TEQ_ASSERT_NXT(a_busy_after_dispatch, multi_take, !in_ready)
  // only delivered events may be followed by more results of the same item
  `TEQ_ASSERT_IMP(a_single_result, out_valid && out_status != ST_DISPATCHED, out_last_result)
  // earliest time is zero with an empty queue
  `TEQ_ASSERT_IMP(a_empty_earliest, out_valid && !out_has_pending, out_earliest_time == 64'd0)
endmodule
`default_nettype wire

[design/tevq_dpath.sv]
// Datapath: sorted shift-register queue, latched time and output register.
// Depends on tevq_pkg.
`default_nettype none
module tevq_dpath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire tevq_pkg::cmd_t           cmd,
  output tevq_pkg::sts_t                sts,
  input  wire logic [tevq_pkg::TIME_W-1:0] in_time_value,
  input  wire logic [tevq_pkg::DEV_W-1:0]  in_device_id,
  input  wire logic [tevq_pkg::RSN_W-1:0]  in_reason_code,
  output logic [1:0]                    out_status,
  output logic [tevq_pkg::TIME_W-1:0]   out_fired_time,
  output logic [tevq_pkg::DEV_W-1:0]    out_fired_device,
  output logic [tevq_pkg::RSN_W-1:0]    out_fired_reason,
  output logic                          out_runaway,
  output logic                          out_has_pending,
  output logic [tevq_pkg::TIME_W-1:0]   out_earliest_time,
  output logic                          out_last_result,
  input  wire logic                     rst_n
);
  import tevq_pkg::*;

  logic [TIME_W-1:0] time_r [QUEUE_DEPTH];
  logic [DEV_W-1:0]  dev_r  [QUEUE_DEPTH];
  logic [RSN_W-1:0]  rsn_r  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] v_r;
  logic [TIME_W-1:0] time_nxt [QUEUE_DEPTH];
  logic [DEV_W-1:0]  dev_nxt  [QUEUE_DEPTH];
  logic [RSN_W-1:0]  rsn_nxt  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] v_nxt;
  logic [QUEUE_DEPTH-1:0] gt;
  logic [TIME_W-1:0] tv_r, pass_r;
  logic [TIME_W-1:0] ins_head;

  // per-cell compare against the incoming insert time
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = v_r[i] && (time_r[i] > in_time_value);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      time_nxt[i] = time_r[i];
      dev_nxt[i]  = dev_r[i];
      rsn_nxt[i]  = rsn_r[i];
      v_nxt[i]    = v_r[i];
      if (cmd.clr) begin
        v_nxt[i] = 1'b0;
      end else if (cmd.pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          time_nxt[i] = time_r[i+1];
          dev_nxt[i]  = dev_r[i+1];
          rsn_nxt[i]  = rsn_r[i+1];
          v_nxt[i]    = v_r[i+1];
        end else begin
          v_nxt[i] = 1'b0;
        end
      end else if (cmd.ins) begin
        if (i > 0 && gt[i-1]) begin
          time_nxt[i] = time_r[i-1];
          dev_nxt[i]  = dev_r[i-1];
          rsn_nxt[i]  = rsn_r[i-1];
        end else if ((gt[i] || !v_r[i]) && (i == 0 || v_r[i-1])) begin
          time_nxt[i] = in_time_value;
          dev_nxt[i]  = in_device_id;
          rsn_nxt[i]  = in_reason_code;
        end
        v_nxt[i] = v_r[i] || (i == 0) || v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    dev_r  <= dev_nxt;
    rsn_r  <= rsn_nxt;
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tv_r <= in_time_value;
    end
    if (cmd.pop) begin
      pass_r <= time_r[0];
    end
  end

  assign sts.head_valid = v_r[0];
  assign sts.next_valid = v_r[1];
  assign sts.full       = v_r[QUEUE_DEPTH-1];
  assign sts.head_due   = time_r[0] <= tv_r;
  assign sts.next_due   = time_r[1] <= tv_r;
  assign sts.head_same  = time_r[0] == pass_r;

  assign ins_head = (v_r[0] && !gt[0]) ? time_r[0] : in_time_value;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status      <= cmd.ostat;
      out_runaway     <= cmd.runaway;
      out_last_result <= cmd.last;
      if (cmd.ostat == ST_DISPATCHED) begin
        out_fired_time   <= time_r[0];
        out_fired_device <= dev_r[0];
        out_fired_reason <= rsn_r[0];
      end else begin
        out_fired_time   <= '0;
        out_fired_device <= '0;
        out_fired_reason <= '0;
      end
      case (cmd.erl)
        ERL_HEAD: begin
          out_has_pending   <= v_r[0];
          out_earliest_time <= v_r[0] ? time_r[0] : '0;
        end
        ERL_AFTER_POP: begin
          out_has_pending   <= v_r[1];
          out_earliest_time <= v_r[1] ? time_r[1] : '0;
        end
        ERL_AFTER_INS: begin
          out_has_pending   <= 1'b1;
          out_earliest_time <= ins_head;
        end
        default: begin
          out_has_pending   <= 1'b0;
          out_earliest_time <= '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[design/tevq_ctrl.sv]
// Controller: handshakes, delivery sequencing, runaway count, limit register.
// Depends on tevq_pkg.
`default_nettype none
module tevq_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_func,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  input  wire logic                       cfg_we,
  input  wire logic [tevq_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire tevq_pkg::sts_t             sts,
  output tevq_pkg::cmd_t                  cmd
);
  import tevq_pkg::*;

  state_t state_r, state_nxt;
  func_t  func_r, func_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_r, n_nxt, cnt_cur;
  logic [LIMIT_W-1:0] limit_r;
  logic out_valid_r, out_valid_nxt;
  logic can_load, flush, more, more_next;

  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign flush     = func_r == FUNC_FLUSH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      func_r      <= FUNC_INSERT;
      cnt_r       <= '0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      func_r      <= func_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    cmd       = '0;
    cmd.ostat = ST_NONE_DUE;
    cmd.erl   = ERL_NONE;
    in_ready  = 1'b0;
    cnt_cur   = '0;
    more      = sts.head_valid && (flush || sts.head_due) &&
                (n_r < CNT_W'(MAX_RESULTS));
    more_next = sts.next_valid && (flush || sts.next_due) &&
                ((n_r + CNT_W'(1)) < CNT_W'(MAX_RESULTS));
    case (state_r)
      S_IDLE: begin
        in_ready = can_load;
        if (in_valid && can_load) begin
          case (func_t'(in_func))
            FUNC_INSERT: begin
              cmd.load = 1'b1;
              cmd.last = 1'b1;
              if (sts.full) begin
                cmd.ostat = ST_FULL;
                cmd.erl   = ERL_HEAD;
              end else begin
                cmd.ins   = 1'b1;
                cmd.ostat = ST_ACCEPTED;
                cmd.erl   = ERL_AFTER_INS;
              end
            end
            FUNC_DISCARD: begin
              cmd.clr  = 1'b1;
              cmd.load = 1'b1;
              cmd.last = 1'b1;
            end
            default: begin
              cmd.latch = 1'b1;
              func_nxt  = func_t'(in_func);
              cnt_nxt   = '0;
              n_nxt     = '0;
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (can_load) begin
          cmd.load = 1'b1;
          if (more) begin
            // flush restarts the count at each new time
            if (flush && (cnt_r == '0 || !sts.head_same)) begin
              cnt_cur = CNT_W'(1);
            end else begin
              cnt_cur = cnt_r + CNT_W'(1);
            end
            cmd.pop     = 1'b1;
            cmd.ostat   = ST_DISPATCHED;
            cmd.erl     = ERL_AFTER_POP;
            cmd.runaway = cnt_cur > CNT_W'(limit_r);
            cmd.last    = !more_next;
            cnt_nxt     = cnt_cur;
            n_nxt       = n_r + CNT_W'(1);
            if (!more_next) begin
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.erl   = ERL_HEAD;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end
endmodule
`default_nettype wire
